// File: rtl/core/olist_pkg.sv
// Operation codes shared by the ordered list engine.
package olist_pkg;

   typedef enum logic [3:0] {
      OP_APPEND     = 4'd0,
      OP_INSERT_AT  = 4'd1,
      OP_REMOVE_VAL = 4'd2,
      OP_REMOVE_AT  = 4'd3,
      OP_SEARCH     = 4'd4,
      OP_GET        = 4'd5,
      OP_ITER_RESET = 4'd6,
      OP_ITER_NEXT  = 4'd7,
      OP_CLEAR      = 4'd8
   } op_type;

   localparam int POS_WIDTH   = 5;
   localparam int COUNT_WIDTH = 5;
   localparam int VALUE_WIDTH = 32;

endpackage

// File: rtl/core/olist_ram.sv
// Generic single-write, single-read RAM with registered read data.
module olist_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/ordered_list_engine_top.sv
// Ordered list engine: list store in RAM walked by a small sequencer.
//
//   channel | direction | ports                                      | handshake
//   req     | in        | req_op, req_value_in, req_position          | req_valid/req_ready
//   rsp     | out       | rsp_ok, rsp_value_out, rsp_count, rsp_is_empty | rsp_valid/rsp_ready
//
// Append, clear, iterator reset and unused codes go straight to the result step; get and
// iterator next pass through a read wait step first. Search, insert at, remove at and remove
// by value walk the list through the single RAM port pair, one element per cycle.
// Reset empties the list and parks the iterator; the RAM contents are left as they are.
// A beat is taken only while the sequencer is idle; a finished result waits in the output
// register, and the sequencer holds in its last step until that register is free.
module ordered_list_engine_top
   import olist_pkg::*;
#(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [3:0]                     req_op,
   input  logic signed [VALUE_WIDTH-1:0]  req_value_in,
   input  logic [POS_WIDTH-1:0]           req_position,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_ok,
   output logic signed [VALUE_WIDTH-1:0]  rsp_value_out,
   output logic [COUNT_WIDTH-1:0]         rsp_count,
   output logic                           rsp_is_empty
);

   localparam int AW   = $clog2(DEPTH);
   localparam int CW   = $clog2(DEPTH + 1);
   localparam int CMPW = (CW > POS_WIDTH) ? CW : POS_WIDTH;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DOWN,
      ST_UP,
      ST_RDWAIT,
      ST_FIN
   } state_type;

   state_type              state_ff;
   logic [3:0]             op_ff;
   logic [DATA_WIDTH-1:0]  key_ff;
   logic [AW-1:0]          p_ff;
   logic [CW-1:0]          cur_ff;
   logic [CW-1:0]          rem_ff;
   logic                   pend_ff;
   logic [AW-1:0]          pwa_ff;
   logic [CW-1:0]          count_ff;
   logic [CW-1:0]          iter_ff;
   logic                   iter_act_ff;
   logic                   ok_ff;
   logic [VALUE_WIDTH-1:0] rd_ff;
   logic                   rsp_valid_ff;
   logic                   rsp_ok_ff;
   logic [VALUE_WIDTH-1:0] rsp_value_ff;
   logic [COUNT_WIDTH-1:0] rsp_count_ff;
   logic                   rsp_empty_ff;

   logic                   mem_wr_en;
   logic [AW-1:0]          mem_wr_addr;
   logic [DATA_WIDTH-1:0]  mem_wr_data;
   logic                   mem_rd_en;
   logic [AW-1:0]          mem_rd_addr;
   logic [DATA_WIDTH-1:0]  mem_rd_data;

   logic [63:0]                  vin_wide;
   logic [DATA_WIDTH-1:0]        req_key;
   logic [CMPW-1:0]              pos_ext;
   logic [CMPW-1:0]              cnt_ext;
   logic [CMPW-1:0]              cnt_next_ext;
   logic                         req_fire;
   logic                         not_full;
   logic                         pos_in_list;
   logic                         pos_insertable;
   logic                         iter_can_read;
   logic                         scan_issue;
   logic                         shift_issue;
   logic                         match;
   logic signed [DATA_WIDTH-1:0] rd_signed;
   logic signed [63:0]           rd_wide;
   logic [CW-1:0]                iter_after_drop;
   logic [CW-1:0]                iter_step;
   logic                         out_free;

   // The key is the low bits of the value, zero-extended when the word is wider than 32 bits.
   assign vin_wide       = {32'd0, req_value_in};
   assign req_key        = vin_wide[DATA_WIDTH-1:0];
   assign pos_ext        = CMPW'(req_position);
   assign cnt_ext        = CMPW'(count_ff);
   assign req_fire       = req_valid && req_ready;
   assign not_full       = count_ff < CW'(DEPTH);
   assign pos_in_list    = pos_ext < cnt_ext;
   assign pos_insertable = (pos_ext <= cnt_ext) && not_full;
   assign iter_can_read  = iter_act_ff && (iter_ff < count_ff);
   assign scan_issue     = cur_ff < count_ff;
   assign shift_issue    = rem_ff != '0;
   assign match          = mem_rd_data == key_ff;
   assign rd_signed      = mem_rd_data;
   assign rd_wide        = 64'(rd_signed);
   assign iter_after_drop = (iter_ff > CW'(p_ff)) ? iter_ff - 1'b1 : iter_ff;
   assign iter_step      = iter_ff + 1'b1;
   assign out_free       = !rsp_valid_ff || rsp_ready;
   assign cnt_next_ext   = CMPW'(count_ff);

   assign req_ready = state_ff == ST_IDLE;

   always_comb begin
      mem_wr_en   = 1'b0;
      mem_wr_addr = pwa_ff;
      mem_wr_data = mem_rd_data;
      mem_rd_en   = 1'b0;
      mem_rd_addr = cur_ff[AW-1:0];
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_op == OP_APPEND && not_full) begin
                  mem_wr_en   = 1'b1;
                  mem_wr_addr = count_ff[AW-1:0];
                  mem_wr_data = req_key;
               end else if (req_op == OP_GET && pos_in_list) begin
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = pos_ext[AW-1:0];
               end else if (req_op == OP_ITER_NEXT && iter_can_read) begin
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = iter_ff[AW-1:0];
               end
            end
         end
         ST_SCAN: begin
            mem_rd_en = scan_issue;
         end
         ST_DOWN: begin
            mem_rd_en = shift_issue;
            mem_wr_en = pend_ff;
         end
         ST_UP: begin
            mem_rd_en = shift_issue;
            if (pend_ff) begin
               mem_wr_en = 1'b1;
            end else if (!shift_issue) begin
               // Shift is done: the new element lands in the opened slot.
               mem_wr_en   = 1'b1;
               mem_wr_addr = p_ff;
               mem_wr_data = key_ff;
            end
         end
         ST_RDWAIT, ST_FIN: begin
         end
         default: begin
         end
      endcase
   end

   olist_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         iter_ff      <= '0;
         iter_act_ff  <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  op_ff   <= req_op;
                  key_ff  <= req_key;
                  p_ff    <= pos_ext[AW-1:0];
                  ok_ff   <= 1'b0;
                  rd_ff   <= '0;
                  pend_ff <= 1'b0;
                  state_ff <= ST_FIN;
                  unique case (req_op)
                     OP_APPEND: begin
                        if (not_full) begin
                           count_ff <= count_ff + 1'b1;
                           ok_ff    <= 1'b1;
                        end
                     end
                     OP_INSERT_AT: begin
                        if (pos_insertable) begin
                           cur_ff   <= count_ff - 1'b1;
                           rem_ff   <= count_ff - CW'(pos_ext);
                           state_ff <= ST_UP;
                        end
                     end
                     OP_REMOVE_VAL, OP_SEARCH: begin
                        cur_ff   <= '0;
                        state_ff <= ST_SCAN;
                     end
                     OP_REMOVE_AT: begin
                        if (pos_in_list) begin
                           cur_ff   <= CW'(pos_ext) + 1'b1;
                           rem_ff   <= count_ff - 1'b1 - CW'(pos_ext);
                           state_ff <= ST_DOWN;
                        end
                     end
                     OP_GET: begin
                        if (pos_in_list) begin
                           state_ff <= ST_RDWAIT;
                        end
                     end
                     OP_ITER_RESET: begin
                        iter_ff     <= '0;
                        iter_act_ff <= count_ff != '0;
                        ok_ff       <= 1'b1;
                     end
                     OP_ITER_NEXT: begin
                        if (iter_can_read) begin
                           iter_ff     <= iter_step;
                           iter_act_ff <= iter_step < count_ff;
                           state_ff    <= ST_RDWAIT;
                        end
                     end
                     OP_CLEAR: begin
                        count_ff    <= '0;
                        iter_ff     <= '0;
                        iter_act_ff <= 1'b0;
                        ok_ff       <= 1'b1;
                     end
                     default: begin
                     end
                  endcase
               end
            end
            ST_SCAN: begin
               // Reads run one ahead of the compare; the compare sees last cycle's read.
               pend_ff <= scan_issue;
               if (scan_issue) begin
                  cur_ff <= cur_ff + 1'b1;
                  pwa_ff <= cur_ff[AW-1:0];
               end
               if (pend_ff && match) begin
                  if (op_ff == OP_SEARCH) begin
                     ok_ff    <= 1'b1;
                     state_ff <= ST_FIN;
                  end else begin
                     p_ff     <= pwa_ff;
                     cur_ff   <= CW'(pwa_ff) + 1'b1;
                     rem_ff   <= count_ff - 1'b1 - CW'(pwa_ff);
                     pend_ff  <= 1'b0;
                     state_ff <= ST_DOWN;
                  end
               end else if (!scan_issue && !pend_ff) begin
                  state_ff <= ST_FIN;
               end
            end
            ST_DOWN: begin
               pend_ff <= shift_issue;
               if (shift_issue) begin
                  cur_ff <= cur_ff + 1'b1;
                  rem_ff <= rem_ff - 1'b1;
                  pwa_ff <= AW'(cur_ff - 1'b1);
               end else if (!pend_ff) begin
                  count_ff <= count_ff - 1'b1;
                  if (iter_act_ff) begin
                     iter_ff     <= iter_after_drop;
                     iter_act_ff <= iter_after_drop < (count_ff - 1'b1);
                  end
                  ok_ff    <= 1'b1;
                  state_ff <= ST_FIN;
               end
            end
            ST_UP: begin
               pend_ff <= shift_issue;
               if (shift_issue) begin
                  cur_ff <= cur_ff - 1'b1;
                  rem_ff <= rem_ff - 1'b1;
                  pwa_ff <= AW'(cur_ff + 1'b1);
               end else if (!pend_ff) begin
                  count_ff <= count_ff + 1'b1;
                  if (iter_act_ff && iter_ff >= CW'(p_ff)) begin
                     iter_ff <= iter_step;
                  end
                  ok_ff    <= 1'b1;
                  state_ff <= ST_FIN;
               end
            end
            ST_RDWAIT: begin
               rd_ff    <= rd_wide[VALUE_WIDTH-1:0];
               ok_ff    <= 1'b1;
               state_ff <= ST_FIN;
            end
            ST_FIN: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_ok_ff    <= ok_ff;
                  rsp_value_ff <= rd_ff;
                  rsp_count_ff <= cnt_next_ext[COUNT_WIDTH-1:0];
                  rsp_empty_ff <= count_ff == '0;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_ok        = rsp_ok_ff;
   assign rsp_value_out = rsp_value_ff;
   assign rsp_count     = rsp_count_ff;
   assign rsp_is_empty  = rsp_empty_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("element count exceeds depth");

   a_iter_in_list: assert property (@(posedge clock) disable iff (reset)
      iter_act_ff |-> (iter_ff < count_ff))
      else $error("active iterator points past the last element");

   a_busy_after_beat: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_ready)
      else $error("request taken while the previous one is still in work");

   a_no_write_when_waiting: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN || state_ff == ST_RDWAIT) |-> !mem_wr_en)
      else $error("store written outside a shift or append step");
`endif

endmodule
